@@ rtl/core/ffia_pkg.sv @@
// shared constants and codes for the first-fit interval allocator
package ffia_pkg;

    localparam int MAX_INTERVALS_DEF = 512;
    localparam int ADDR_WIDTH_DEF    = 32;

    localparam int SIZE_W  = 32;
    localparam int PAD_W   = 31;
    localparam int COUNT_W = 10;

    // command codes
    localparam logic CMD_ALLOC   = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    // result status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NO_FIT  = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_DROPPED = 2'd3;

endpackage

@@ rtl/core/ffia_table.sv @@
// free-interval table memory, one write and one registered read per cycle
module ffia_table #(
    parameter int DEPTH = 512,
    parameter int DW    = 64
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [DW-1:0]            i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [DW-1:0]            o_rd_data
);
    localparam int IW = $clog2(DEPTH);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rd;
    logic          r_e0_reset;
    logic          r_rd_zero;

    // storage and read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd <= r_mem[i_rd_addr];
        end
    end

    // entry 0 reads as zero until first written after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e0_reset <= 1'b1;
            r_rd_zero  <= 1'b0;
        end else begin
            if (i_rd_en) begin
                r_rd_zero <= r_e0_reset && (i_rd_addr == IW'(0))
                             && !(i_wr_en && i_wr_addr == IW'(0));
            end
            if (i_wr_en && i_wr_addr == IW'(0)) begin
                r_e0_reset <= 1'b0;
            end
        end
    end

    assign o_rd_data = r_rd_zero ? '0 : r_rd;

endmodule

@@ rtl/core/ffia_ctrl.sv @@
// sequencer and shared datapath for allocate and release scans
module ffia_ctrl #(
    parameter int MAX_INTERVALS = 512,
    parameter int ADDR_WIDTH    = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [ffia_pkg::SIZE_W-1:0]   i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_command,
    input  logic [ffia_pkg::SIZE_W-1:0]   i_req_size,
    input  logic [ffia_pkg::SIZE_W-1:0]   i_alignment,
    input  logic [ffia_pkg::SIZE_W-1:0]   i_release_offset,
    input  logic [ffia_pkg::PAD_W-1:0]    i_release_padding,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [1:0]                    o_status,
    output logic [ffia_pkg::SIZE_W-1:0]   o_alloc_offset,
    output logic [ffia_pkg::PAD_W-1:0]    o_left_padding,
    output logic [ffia_pkg::COUNT_W-1:0]  o_interval_count,
    output logic                          o_wr_en,
    output logic [$clog2(MAX_INTERVALS)-1:0] o_wr_addr,
    output logic [2*ADDR_WIDTH-1:0]       o_wr_data,
    output logic                          o_rd_en,
    output logic [$clog2(MAX_INTERVALS)-1:0] o_rd_addr,
    input  logic [2*ADDR_WIDTH-1:0]       i_rd_data
);
    import ffia_pkg::*;

    localparam int AW = ADDR_WIDTH;
    localparam int IW = $clog2(MAX_INTERVALS);
    localparam int NW = $clog2(MAX_INTERVALS + 1);
    localparam int CW = (AW > SIZE_W) ? AW : SIZE_W;

    typedef enum logic [3:0] {
        S_IDLE, S_MASK, S_ASCAN, S_APAD, S_AFIT, S_RSCAN, S_RCHK, S_RLOW,
        S_RUP, S_ERD, S_EWR, S_RINS, S_IRD, S_IWR, S_DONE
    } t_state;

    t_state            r_state, n_state;
    logic [NW-1:0]     r_used, n_used;
    logic [NW-1:0]     r_pos, n_pos;
    logic [NW-1:0]     r_i, n_i;
    logic              r_cmd;
    logic [SIZE_W-1:0] r_size, r_align, r_cnt, n_cnt, r_mask, n_mask;
    logic [AW-1:0]     r_roff, r_rlen, r_rend;
    logic [AW-1:0]     r_ns, n_ns, r_nl, n_nl;
    logic [CW-1:0]     r_p, n_p;
    logic [1:0]        r_st, n_st;
    logic [SIZE_W-1:0] r_off, n_off;
    logic [PAD_W-1:0]  r_pad, n_pad;
    logic              r_ov;
    logic [1:0]        r_ost;
    logic [SIZE_W-1:0] r_ooff;
    logic [PAD_W-1:0]  r_opad;
    logic [COUNT_W-1:0] r_ocnt;

    logic [AW-1:0] s, l, s_plus_l;
    logic [CW-1:0] s_c, l_c, size_c;
    logic          accept;

    assign s        = i_rd_data[2*AW-1:AW];
    assign l        = i_rd_data[AW-1:0];
    assign s_plus_l = s + l;
    assign s_c      = CW'(s);
    assign l_c      = CW'(l);
    assign size_c   = CW'(r_size);
    assign accept   = i_in_valid && o_in_ready;

    assign o_in_ready       = (r_state == S_IDLE);
    assign o_out_valid      = r_ov;
    assign o_status         = r_ost;
    assign o_alloc_offset   = r_ooff;
    assign o_left_padding   = r_opad;
    assign o_interval_count = r_ocnt;

    // next-state logic and memory port control
    always_comb begin
        n_state = r_state;
        n_used  = r_used;
        n_pos   = r_pos;
        n_i     = r_i;
        n_cnt   = r_cnt;
        n_mask  = r_mask;
        n_ns    = r_ns;
        n_nl    = r_nl;
        n_p     = r_p;
        n_st    = r_st;
        n_off   = r_off;
        n_pad   = r_pad;
        o_wr_en   = 1'b0;
        o_wr_addr = r_pos[IW-1:0];
        o_wr_data = '0;
        o_rd_en   = 1'b0;
        o_rd_addr = r_pos[IW-1:0];
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_st  = ST_OK;
                    n_off = '0;
                    n_pad = '0;
                    n_pos = '0;
                    n_cnt = i_alignment;
                    n_mask = '0;
                    n_state = (i_command == CMD_ALLOC) ? S_MASK : S_RSCAN;
                end
            end
            // alignment mask, one bit a cycle
            S_MASK: begin
                if (r_cnt > SIZE_W'(1)) begin
                    n_mask = {r_mask[SIZE_W-2:0], 1'b1};
                    n_cnt  = r_cnt >> 1;
                end else begin
                    n_state = S_ASCAN;
                end
            end
            S_ASCAN: begin
                if (r_pos >= r_used) begin
                    n_st    = ST_NO_FIT;
                    n_state = S_DONE;
                end else begin
                    o_rd_en = 1'b1;
                    n_state = S_APAD;
                end
            end
            S_APAD: begin
                n_p     = (CW'(r_align) - (s_c & CW'(r_mask))) & CW'(r_mask);
                n_state = S_AFIT;
            end
            S_AFIT: begin
                if (r_p <= l_c && size_c <= l_c - r_p) begin
                    if (r_used >= NW'(MAX_INTERVALS)) begin
                        n_st = ST_FULL;
                    end else begin
                        o_wr_en   = 1'b1;
                        o_wr_data = {AW'(s_c + r_p + size_c), AW'(l_c - r_p - size_c)};
                        n_off     = SIZE_W'(AW'(s_c + r_p));
                        n_pad     = PAD_W'(r_p);
                    end
                    n_state = S_DONE;
                end else begin
                    n_pos   = r_pos + NW'(1);
                    n_state = S_ASCAN;
                end
            end
            S_RSCAN: begin
                if (r_pos >= r_used) begin
                    n_state = S_RINS;
                end else begin
                    o_rd_en = 1'b1;
                    n_state = S_RCHK;
                end
            end
            // edge-touch tests against one entry, else insert here or move to the next entry
            S_RCHK: begin
                if (r_rend == s) begin
                    n_ns      = s - r_rlen;
                    n_nl      = l + r_rlen;
                    o_wr_en   = 1'b1;
                    o_wr_data = {n_ns, n_nl};
                    if (r_pos != '0) begin
                        o_rd_en   = 1'b1;
                        o_rd_addr = IW'(r_pos - NW'(1));
                        n_state   = S_RLOW;
                    end else begin
                        n_state = S_DONE;
                    end
                end else if (r_roff == s_plus_l) begin
                    n_ns      = s;
                    n_nl      = l + r_rlen;
                    o_wr_en   = 1'b1;
                    o_wr_data = {n_ns, n_nl};
                    if (r_pos + NW'(1) < r_used) begin
                        o_rd_en   = 1'b1;
                        o_rd_addr = IW'(r_pos + NW'(1));
                        n_state   = S_RUP;
                    end else begin
                        n_state = S_DONE;
                    end
                end else if (s > r_roff) begin
                    n_state = S_RINS;
                end else begin
                    n_pos   = r_pos + NW'(1);
                    n_state = S_RSCAN;
                end
            end
            S_RLOW: begin
                if (s_plus_l == r_ns) begin
                    o_wr_en   = 1'b1;
                    o_wr_addr = IW'(r_pos - NW'(1));
                    o_wr_data = {s, l + r_nl};
                    n_i       = r_pos;
                    n_state   = S_ERD;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_RUP: begin
                if (r_ns + r_nl == s) begin
                    o_wr_en   = 1'b1;
                    o_wr_addr = IW'(r_pos + NW'(1));
                    o_wr_data = {s - r_nl, l + r_nl};
                    n_i       = r_pos;
                    n_state   = S_ERD;
                end else begin
                    n_state = S_DONE;
                end
            end
            // erase: shift entries down one place
            S_ERD: begin
                if (r_i + NW'(1) < r_used) begin
                    o_rd_en   = 1'b1;
                    o_rd_addr = IW'(r_i + NW'(1));
                    n_state   = S_EWR;
                end else begin
                    n_used  = r_used - NW'(1);
                    n_state = S_DONE;
                end
            end
            S_EWR: begin
                o_wr_en   = 1'b1;
                o_wr_addr = r_i[IW-1:0];
                o_wr_data = i_rd_data;
                n_i       = r_i + NW'(1);
                n_state   = S_ERD;
            end
            S_RINS: begin
                if (r_used >= NW'(MAX_INTERVALS)) begin
                    n_st    = ST_DROPPED;
                    n_state = S_DONE;
                end else begin
                    n_i     = r_used;
                    n_state = S_IRD;
                end
            end
            // insert: shift entries up one place, then place the new one
            S_IRD: begin
                if (r_i > r_pos) begin
                    o_rd_en   = 1'b1;
                    o_rd_addr = IW'(r_i - NW'(1));
                    n_state   = S_IWR;
                end else begin
                    o_wr_en   = 1'b1;
                    o_wr_data = {r_roff, r_rlen};
                    n_used    = r_used + NW'(1);
                    n_state   = S_DONE;
                end
            end
            S_IWR: begin
                o_wr_en   = 1'b1;
                o_wr_addr = r_i[IW-1:0];
                o_wr_data = i_rd_data;
                n_i       = r_i - NW'(1);
                n_state   = S_IRD;
            end
            S_DONE: begin
                if (!r_ov || i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        // pool size write reinitialises the table
        if (i_cfg_we) begin
            o_wr_en   = 1'b1;
            o_wr_addr = '0;
            o_wr_data = {AW'(0), AW'(i_cfg_data)};
            n_used    = NW'(1);
        end
    end

    // state, interval count and output valid registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_used  <= NW'(1);
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_used  <= n_used;
            if (r_state == S_DONE && (!r_ov || i_out_ready)) begin
                r_ov <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_pos  <= n_pos;
        r_i    <= n_i;
        r_cnt  <= n_cnt;
        r_mask <= n_mask;
        r_ns   <= n_ns;
        r_nl   <= n_nl;
        r_p    <= n_p;
        r_st   <= n_st;
        r_off  <= n_off;
        r_pad  <= n_pad;
        if (accept) begin
            r_cmd   <= i_command;
            r_size  <= i_req_size;
            r_align <= i_alignment;
            r_roff  <= AW'(CW'(i_release_offset) - CW'(i_release_padding));
            r_rlen  <= AW'(CW'(i_req_size) + CW'(i_release_padding));
        end
        if (r_state == S_RSCAN && r_pos == '0) begin
            r_rend <= r_roff + r_rlen;
        end
        if (r_state == S_DONE && (!r_ov || i_out_ready)) begin
            r_ost  <= r_st;
            r_ooff <= (r_cmd == CMD_ALLOC) ? r_off : '0;
            r_opad <= (r_cmd == CMD_ALLOC) ? r_pad : '0;
            r_ocnt <= COUNT_W'(r_used);
        end
    end

endmodule

@@ rtl/core/first_fit_interval_allocator_unit.sv @@
// top level of the first-fit interval allocator
//
//  channel  | handshake                | payload
//  ---------+--------------------------+----------------------------------------------
//  input    | i_in_valid / o_in_ready  | command, req_size, alignment, release_offset/padding
//  output   | o_out_valid / i_out_ready| status, alloc_offset, left_padding, interval_count
//  config   | i_cfg_we                 | i_cfg_data (pool size)
//
// one word at a time; the table memory has one read and one write port, so
// allocate scans the entries one at a time, and release scans them and then
// shifts entries up on insert or down on erase.
// reset leaves one empty interval; a pool size write rebuilds it at once.
// a waiting result is held in the output register; new words are taken
// meanwhile and finish only when that register is free.
module first_fit_interval_allocator_unit #(
    parameter int MAX_INTERVALS = ffia_pkg::MAX_INTERVALS_DEF,
    parameter int ADDR_WIDTH    = ffia_pkg::ADDR_WIDTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [ffia_pkg::SIZE_W-1:0]  i_cfg_data,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic                         i_command,
    input  logic [ffia_pkg::SIZE_W-1:0]  i_req_size,
    input  logic [ffia_pkg::SIZE_W-1:0]  i_alignment,
    input  logic [ffia_pkg::SIZE_W-1:0]  i_release_offset,
    input  logic [ffia_pkg::PAD_W-1:0]   i_release_padding,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [1:0]                   o_status,
    output logic [ffia_pkg::SIZE_W-1:0]  o_alloc_offset,
    output logic [ffia_pkg::PAD_W-1:0]   o_left_padding,
    output logic [ffia_pkg::COUNT_W-1:0] o_interval_count
);
    import ffia_pkg::*;

    localparam int IW = $clog2(MAX_INTERVALS);
    localparam int DW = 2 * ADDR_WIDTH;

    logic          wr_en, rd_en;
    logic [IW-1:0] wr_addr, rd_addr;
    logic [DW-1:0] wr_data, rd_data;

    // sequencer
    ffia_ctrl #(
        .MAX_INTERVALS(MAX_INTERVALS),
        .ADDR_WIDTH   (ADDR_WIDTH)
    ) u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_command        (i_command),
        .i_req_size       (i_req_size),
        .i_alignment      (i_alignment),
        .i_release_offset (i_release_offset),
        .i_release_padding(i_release_padding),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_status         (o_status),
        .o_alloc_offset   (o_alloc_offset),
        .o_left_padding   (o_left_padding),
        .o_interval_count (o_interval_count),
        .o_wr_en          (wr_en),
        .o_wr_addr        (wr_addr),
        .o_wr_data        (wr_data),
        .o_rd_en          (rd_en),
        .o_rd_addr        (rd_addr),
        .i_rd_data        (rd_data)
    );

    // interval table
    ffia_table #(
        .DEPTH(MAX_INTERVALS),
        .DW   (DW)
    ) u_table (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr_en  (wr_en),
        .i_wr_addr(wr_addr),
        .i_wr_data(wr_data),
        .i_rd_en  (rd_en),
        .i_rd_addr(rd_addr),
        .o_rd_data(rd_data)
    );

endmodule
